### rtl/core/bqd_pkg.sv
// Shared types, codes and defaults of the biquad IIR filter section.
`default_nettype none

package bqd_pkg;

    // Default geometry of the section
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_COEF_FRAC_BITS  = 28;
    localparam int DEF_STATE_FRAC_BITS = 30;
    localparam int DEF_STATE_BITS      = 48;

    // Coefficient register file
    localparam int COEF_W    = 32;
    localparam int NUM_COEFS = 5;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int CIDX_W    = APB_AW - 2;

    typedef enum logic [CIDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_idx_t;

    localparam logic [COEF_W-1:0] B0_RESET    = 32'h1000_0000;
    localparam logic [COEF_W-1:0] COEF_ZERO   = 32'h0000_0000;

    // Multiplier operand A source
    typedef enum logic [1:0] {
        OPA_X   = 2'd0,
        OPA_YLO = 2'd1,
        OPA_YHI = 2'd2
    } opa_sel_t;

    // Accumulator action taken on the product that is present this cycle
    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_Y      = 3'd1,
        ACC_S1_X   = 3'd2,
        ACC_S2_X   = 3'd3,
        ACC_LO     = 3'd4,
        ACC_S1_SUB = 3'd5,
        ACC_S2_SUB = 3'd6
    } acc_op_t;

    typedef struct packed {
        opa_sel_t  a_sel;
        coef_idx_t c_sel;
        acc_op_t   acc_op;
        logic      fin;
    } bqd_ctl_t;

endpackage

`default_nettype wire

### rtl/core/bqd_mult.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module bqd_mult #(
    parameter int A_W = 33
) (
    input  wire                                    aclk,
    input  wire  signed [A_W-1:0]                  op_a,
    input  wire  signed [bqd_pkg::COEF_W-1:0]      op_b,
    output logic signed [A_W+bqd_pkg::COEF_W-1:0]  prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

`default_nettype wire

### rtl/core/bqd_ctrl.sv
// Step sequencer that schedules the five multiply-accumulates of one sample.
`default_nettype none

module bqd_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_fire,
    input  wire               out_free,
    output logic              in_ready,
    output bqd_pkg::bqd_ctl_t ctl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_A1L,
        ST_A1H,
        ST_A2L,
        ST_A2H,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_MB0;
            ST_MB0:  state_next = ST_MB1;
            ST_MB1:  state_next = ST_MB2;
            ST_MB2:  state_next = ST_A1L;
            ST_A1L:  state_next = ST_A1H;
            ST_A1H:  state_next = ST_A2L;
            ST_A2L:  state_next = ST_A2H;
            ST_A2H:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Issue an operand pair and act on the product issued one step earlier
    always_comb begin
        ctl = '{a_sel: bqd_pkg::OPA_X, c_sel: bqd_pkg::COEF_B0,
                acc_op: bqd_pkg::ACC_NONE, fin: 1'b0};
        case (state_reg)
            ST_MB0: begin
                ctl.c_sel = bqd_pkg::COEF_B0;
            end
            ST_MB1: begin
                ctl.c_sel  = bqd_pkg::COEF_B1;
                ctl.acc_op = bqd_pkg::ACC_Y;
            end
            ST_MB2: begin
                ctl.c_sel  = bqd_pkg::COEF_B2;
                ctl.acc_op = bqd_pkg::ACC_S1_X;
            end
            ST_A1L: begin
                ctl.a_sel  = bqd_pkg::OPA_YLO;
                ctl.c_sel  = bqd_pkg::COEF_A1;
                ctl.acc_op = bqd_pkg::ACC_S2_X;
            end
            ST_A1H: begin
                ctl.a_sel  = bqd_pkg::OPA_YHI;
                ctl.c_sel  = bqd_pkg::COEF_A1;
                ctl.acc_op = bqd_pkg::ACC_LO;
            end
            ST_A2L: begin
                ctl.a_sel  = bqd_pkg::OPA_YLO;
                ctl.c_sel  = bqd_pkg::COEF_A2;
                ctl.acc_op = bqd_pkg::ACC_S1_SUB;
            end
            ST_A2H: begin
                ctl.a_sel  = bqd_pkg::OPA_YHI;
                ctl.c_sel  = bqd_pkg::COEF_A2;
                ctl.acc_op = bqd_pkg::ACC_LO;
            end
            ST_DONE: begin
                // keep issuing the same pair so the product holds while stalled
                ctl.a_sel  = bqd_pkg::OPA_YHI;
                ctl.c_sel  = bqd_pkg::COEF_A2;
                ctl.acc_op = bqd_pkg::ACC_S2_SUB;
                ctl.fin    = 1'b1;
            end
            default: begin
                ctl.acc_op = bqd_pkg::ACC_NONE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/bqd_sat.sv
// Output rescale toward zero and saturation to the sample range.
`default_nettype none

module bqd_sat #(
    parameter int SAMPLE_BITS     = bqd_pkg::DEF_SAMPLE_BITS,
    parameter int STATE_FRAC_BITS = bqd_pkg::DEF_STATE_FRAC_BITS,
    parameter int STATE_BITS      = bqd_pkg::DEF_STATE_BITS
) (
    input  wire  [STATE_BITS-1:0]  y_in,
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic                   clipped
);

    localparam int OSH   = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
    localparam int OSH_R = (OSH > 0) ? OSH : 0;
    localparam int OSH_L = (OSH < 0) ? -OSH : 0;
    localparam int MAG_W = STATE_BITS + 1;
    localparam int SW    = MAG_W + OSH_L;

    localparam logic [SW-1:0] NEG_MAX = SW'(1) << (SAMPLE_BITS - 1);
    localparam logic [SW-1:0] POS_MAX = NEG_MAX - SW'(1);

    logic              neg;
    logic [MAG_W-1:0]  ye;
    logic [MAG_W-1:0]  mag;
    logic [SW-1:0]     scaled;
    logic [SW-1:0]     lim;
    logic [SW-1:0]     clamped;
    logic [SW-1:0]     res;

    always_comb begin
        neg     = y_in[STATE_BITS-1];
        ye      = MAG_W'($signed(y_in));
        mag     = neg ? (~ye + MAG_W'(1)) : ye;
        // full-width rescale of the magnitude, so the compare sees any overflow
        scaled  = (SW'(mag) << OSH_L) >> OSH_R;
        lim     = neg ? NEG_MAX : POS_MAX;
        clipped = (scaled > lim);
        clamped = clipped ? lim : scaled;
        res     = neg ? (~clamped + SW'(1)) : clamped;
        sample_out = res[SAMPLE_BITS-1:0];
    end

endmodule

`default_nettype wire

### rtl/core/biquad_iir_filter.sv
// Top level of the biquad IIR section: datapath, coefficient registers, stream ports.
//
// Second-order IIR section in direct form II transposed, fixed point.
//   y = b0*x + s1;  s1' = b1*x - a1*y + s2;  s2' = b2*x - a2*y
// Input stream (s_*): s_tdata carries the signed sample in its low bits, s_tlast
// marks the last sample of a software block and is passed through unchanged.
// Output stream (m_*): m_tdata carries the filtered, saturated sample, m_tuser
// is set when the sample was clipped, m_tlast echoes the input marker.
// Coefficients b0, b1, b2, a1, a2 sit on the APB port at byte addresses 0..16;
// write them only while the section is idle. Reset loads b0 = 1.0, the others 0.
// Datapath: one shared signed multiplier (25x32 at the default sizes) serves all
// five products (the two feedback products take two passes each, low and high
// half of y), and s_tready is high only in the idle step, so a new item is taken
// only once the previous result has gone into the output register.
// The result waits in an output register; if the receiver stalls, the
// sequencer holds in its last step until the register frees, so nothing
// is lost. Synchronous active-low reset clears the state, reloads the
// coefficients and drops m_tvalid; s_tready is high after reset.
`default_nettype none

module biquad_iir_filter #(
    parameter int SAMPLE_BITS     = bqd_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS  = bqd_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_FRAC_BITS = bqd_pkg::DEF_STATE_FRAC_BITS,
    parameter int STATE_BITS      = bqd_pkg::DEF_STATE_BITS,
    localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // APB coefficient port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [bqd_pkg::APB_AW-1:0]   paddr,
    input  wire  [bqd_pkg::APB_DW-1:0]   pwdata,
    output logic [bqd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // input samples
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [DATA_W-1:0]            s_tdata,   // sample_in, zero pad
    input  wire                          s_tlast,   // block_end
    // filtered samples
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [DATA_W-1:0]            m_tdata,   // sample_out, zero pad
    output logic                         m_tuser,   // clipped
    output logic                         m_tlast    // block_end_out
);

    localparam int LO_BITS = STATE_BITS / 2;
    localparam int A_W     = (SAMPLE_BITS > LO_BITS + 1) ? SAMPLE_BITS : LO_BITS + 1;
    localparam int PW      = A_W + bqd_pkg::COEF_W;
    localparam int XSH     = (SAMPLE_BITS - 1) + COEF_FRAC_BITS - STATE_FRAC_BITS;
    localparam int XSH_R   = (XSH > 0) ? XSH : 0;
    localparam int XSH_L   = (XSH < 0) ? -XSH : 0;
    localparam int WX      = PW + STATE_BITS + XSH_L;
    localparam int WY      = PW + LO_BITS + 1;

    // ---------------- coefficient registers ----------------
    logic [bqd_pkg::COEF_W-1:0] coef_reg [bqd_pkg::NUM_COEFS];
    logic [bqd_pkg::CIDX_W-1:0] cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[bqd_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[bqd_pkg::COEF_B0] <= bqd_pkg::B0_RESET;
            coef_reg[bqd_pkg::COEF_B1] <= bqd_pkg::COEF_ZERO;
            coef_reg[bqd_pkg::COEF_B2] <= bqd_pkg::COEF_ZERO;
            coef_reg[bqd_pkg::COEF_A1] <= bqd_pkg::COEF_ZERO;
            coef_reg[bqd_pkg::COEF_A2] <= bqd_pkg::COEF_ZERO;
        end else if (cfg_wr && (int'(cfg_idx) < bqd_pkg::NUM_COEFS)) begin
            coef_reg[cfg_idx] <= pwdata;
        end
    end

    // drop reads beyond the register list to zero
    always_comb begin
        prdata = '0;
        if (int'(cfg_idx) < bqd_pkg::NUM_COEFS) begin
            prdata = coef_reg[cfg_idx];
        end
    end

    // ---------------- sequencer ----------------
    bqd_pkg::bqd_ctl_t ctl;
    logic              in_fire;
    logic              out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    bqd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctl      (ctl)
    );

    // ---------------- shared multiplier ----------------
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          last_reg;
    logic signed [STATE_BITS-1:0]  y_reg;
    logic signed [A_W-1:0]         op_a;
    logic signed [PW-1:0]          prod;

    always_comb begin
        case (ctl.a_sel)
            bqd_pkg::OPA_X:   op_a = A_W'(x_reg);
            bqd_pkg::OPA_YLO: op_a = A_W'({1'b0, y_reg[LO_BITS-1:0]});
            bqd_pkg::OPA_YHI: op_a = A_W'($signed(y_reg[STATE_BITS-1:LO_BITS]));
            default:          op_a = '0;
        endcase
    end

    bqd_mult #(
        .A_W (A_W)
    ) u_mult (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     ($signed(coef_reg[ctl.c_sel])),
        .prod_reg (prod)
    );

    // ---------------- product scaling ----------------
    // Sample products: floor to STATE_FRAC_BITS fractional bits (or shift up).
    logic signed [WX-1:0]         xw;
    logic signed [WX-1:0]         xsc;
    logic signed [STATE_BITS-1:0] xs;
    // Feedback products: join the high and low halves, then floor by the
    // coefficient's fraction.
    logic signed [PW-1:0]         lo_reg;
    logic signed [WY-1:0]         yw;
    logic signed [WY-1:0]         ysc;
    logic signed [STATE_BITS-1:0] yc;

    always_comb begin
        xw  = WX'(prod);
        xsc = (xw <<< XSH_L) >>> XSH_R;
        xs  = xsc[STATE_BITS-1:0];
        yw  = (WY'(prod) <<< LO_BITS) + WY'(lo_reg);
        ysc = yw >>> COEF_FRAC_BITS;
        yc  = ysc[STATE_BITS-1:0];
    end

    // ---------------- accumulators and state ----------------
    logic signed [STATE_BITS-1:0] s1_reg;
    logic signed [STATE_BITS-1:0] s2_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x_reg    <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            last_reg <= s_tlast;
        end
        case (ctl.acc_op)
            bqd_pkg::ACC_Y:  y_reg  <= xs + s1_reg;
            bqd_pkg::ACC_LO: lo_reg <= prod;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            case (ctl.acc_op)
                bqd_pkg::ACC_S1_X:   s1_reg <= xs + s2_reg;
                bqd_pkg::ACC_S2_X:   s2_reg <= xs;
                bqd_pkg::ACC_S1_SUB: s1_reg <= s1_reg - yc;
                bqd_pkg::ACC_S2_SUB: if (out_free) s2_reg <= s2_reg - yc;
                default: ;
            endcase
        end
    end

    // ---------------- output formatting and register ----------------
    logic [SAMPLE_BITS-1:0] sat_sample;
    logic                   sat_clip;

    bqd_sat #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .STATE_FRAC_BITS (STATE_FRAC_BITS),
        .STATE_BITS      (STATE_BITS)
    ) u_sat (
        .y_in       (y_reg),
        .sample_out (sat_sample),
        .clipped    (sat_clip)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (ctl.fin && out_free) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin && out_free) begin
            m_tdata <= DATA_W'(sat_sample);
            m_tuser <= sat_clip;
            m_tlast <= last_reg;
        end
    end

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted while a sample was still in work");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctl.fin))
        else $error("result appeared without a finished sequence");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fin && !out_free) |=> (ctl.fin && !s_tready))
        else $error("sequencer left its last step while the output was full");

endmodule

`default_nettype wire
